>>> design/pt1000_adc_to_temperature_assert.svh
// Assertion macros shared by the PT1000 conversion RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef PT1000_ADC_TO_TEMPERATURE_ASSERT_SVH
`define PT1000_ADC_TO_TEMPERATURE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define PT1K_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define PT1K_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PT1K_ASSERT_SAME(lbl, ante, cons, msg)
`define PT1K_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/pt1k_pkg.sv
// Constants and widths for the PT1000 sample to temperature pipeline.
// No dependencies; used by pt1000_adc_to_temperature.
`default_nettype none
package pt1k_pkg;
    localparam int ADC_BITS = 12;
    localparam int D_W      = ADC_BITS + 1;       // divisor 2^ADC_BITS - s
    localparam int REF_W    = 14;
    localparam int RS_W     = REF_W + ADC_BITS;   // reference * sample
    localparam int P_W      = 21 + ADC_BITS;      // 1759246 * divisor
    localparam int NG_W     = 22 + ADC_BITS;      // 232 * reference * sample
    localparam int NUM_W    = P_W + 24;           // root argument times 1e7
    localparam int Q_W      = 45;                 // quotient stays below 1.8e13
    localparam int S_W      = 23;                 // integer root bits
    localparam int SQ_W     = 2 * S_W;
    localparam int MAG_W    = 23;
    localparam int MUL_W    = 29;
    localparam int PROD_W   = MAG_W + MUL_W;
    localparam int T_W      = 20;

    localparam logic [REF_W-1:0] REF_RESET = REF_W'(1000);
    localparam logic [20:0]      K_POS     = 21'd1759246;
    localparam logic [23:0]      K_SCALE   = 24'd10000000;
    localparam logic [7:0]       K_NEG     = 8'd232;
    localparam logic [23:0]      K_OFFSET  = 24'd3908000;
    // 5 * ceil(2^32 / 58): multiply then drop 32 bits gives mag * 5 / 58
    localparam logic [MUL_W-1:0] K_RECIP   = 29'd370255805;
endpackage
`default_nettype wire

>>> design/pt1000_adc_to_temperature.sv
// PT1000 divider sample to temperature: fully pipelined conversion.
// Depends on pt1k_pkg and pt1000_adc_to_temperature_assert.svh.
//
// Usage: samples arrive on the slave stream (sample in tdata[11:0]); the
// divider resistor value is written through i_cfg_we / i_cfg_wdata while no
// request is in flight. Each sample gives one result on the master stream:
// temperature in 0.01 degC in tdata[19:0], in-range flag in tuser[0].
// Out-of-range samples (negative root argument) return zero temperature.
// The pipeline holds four front stages for the resistance terms, one for
// scaling, 45 restoring division stages (one quotient bit each), 23 square
// root stages (one result bit each) and three stages for the final scaling.
// Throughput is one sample per cycle. All stages share one advance enable:
// when the receiver stalls with a result waiting, the whole pipeline holds
// and o_s_tready drops, so nothing is lost or repeated. Reset clears every
// valid bit and sets the reference to 1000 ohms; no clearing pass is needed.
`default_nettype none
`include "pt1000_adc_to_temperature_assert.svh"
module pt1000_adc_to_temperature (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [13:0] i_cfg_wdata,  // reference_ohms
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,    // [11:0] sample, rest ignored
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,    // [19:0] temp_centi, rest zero
    output logic [0:0]       o_m_tuser     // [0] in_range
);
    localparam int A  = pt1k_pkg::ADC_BITS;
    localparam int DW = pt1k_pkg::D_W;
    localparam int QW = pt1k_pkg::Q_W;
    localparam int SW = pt1k_pkg::S_W;
    localparam int XW = pt1k_pkg::SQ_W;

    logic w_en;

    // Configuration register
    logic [pt1k_pkg::REF_W-1:0] r_ref;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= pt1k_pkg::REF_RESET;
        end else if (i_cfg_we) begin
            r_ref <= i_cfg_wdata;
        end
    end

    // Stage A: capture sample and divisor
    logic          r_a_vld;
    logic [A-1:0]  r_a_s;
    logic [DW-1:0] r_a_d;
    // Stage B: positive term and reference times sample
    logic                        r_b_vld;
    logic [pt1k_pkg::P_W-1:0]    r_b_pos;
    logic [pt1k_pkg::RS_W-1:0]   r_b_rs;
    logic [DW-1:0]               r_b_d;
    // Stage C: negative term
    logic                        r_c_vld;
    logic [pt1k_pkg::P_W-1:0]    r_c_pos;
    logic [pt1k_pkg::NG_W-1:0]   r_c_neg;
    logic [DW-1:0]               r_c_d;
    // Stage D: root argument times divisor
    logic                        r_d_vld;
    logic                        r_d_ok;
    logic [pt1k_pkg::P_W-1:0]    r_d_n;
    logic [DW-1:0]               r_d_d;

    assign w_en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_s   <= i_s_tdata[A-1:0];
            r_a_d   <= (DW'(1) << A) - DW'(i_s_tdata[A-1:0]);
            r_b_pos <= pt1k_pkg::P_W'(pt1k_pkg::K_POS) * pt1k_pkg::P_W'(r_a_d);
            r_b_rs  <= pt1k_pkg::RS_W'(r_ref) * pt1k_pkg::RS_W'(r_a_s);
            r_b_d   <= r_a_d;
            r_c_pos <= r_b_pos;
            r_c_neg <= pt1k_pkg::NG_W'(pt1k_pkg::K_NEG) * pt1k_pkg::NG_W'(r_b_rs);
            r_c_d   <= r_b_d;
            r_d_ok  <= (pt1k_pkg::NG_W'(r_c_pos) >= r_c_neg) && (r_c_d != '0);
            r_d_n   <= r_c_pos - pt1k_pkg::P_W'(r_c_neg);
            r_d_d   <= r_c_d;
        end
    end

    // Restoring division: entry 0 holds the scaled numerator, each later
    // entry one more quotient bit.
    logic                          r_dv_vld [0:QW];
    logic                          r_dv_ok  [0:QW];
    logic [pt1k_pkg::NUM_W-1:0]    r_dv_num [0:QW];
    logic [DW-1:0]                 r_dv_den [0:QW];
    logic [DW-1:0]                 r_dv_rem [0:QW];
    logic [QW-1:0]                 r_dv_q   [0:QW];
    logic [pt1k_pkg::NUM_W-1:0]    w_scaled;

    assign w_scaled = pt1k_pkg::NUM_W'(r_d_n) * pt1k_pkg::NUM_W'(pt1k_pkg::K_SCALE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_dv_vld[0] <= r_d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_ok[0]  <= r_d_ok;
            r_dv_num[0] <= w_scaled;
            r_dv_den[0] <= r_d_d;
            r_dv_rem[0] <= DW'(w_scaled[pt1k_pkg::NUM_W-1:QW]);
            r_dv_q[0]   <= '0;
        end
    end

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [DW:0] w_trial;
        logic        w_take;
        assign w_trial = {r_dv_rem[j], r_dv_num[j][QW-1-j]};
        assign w_take  = w_trial >= {1'b0, r_dv_den[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_ok[j+1]  <= r_dv_ok[j];
                r_dv_num[j+1] <= r_dv_num[j];
                r_dv_den[j+1] <= r_dv_den[j];
                r_dv_rem[j+1] <= w_take ? DW'(w_trial - {1'b0, r_dv_den[j]})
                                        : DW'(w_trial);
                r_dv_q[j+1]   <= {r_dv_q[j][QW-2:0], w_take};
            end
        end
    end

    // Integer square root, one result bit per stage.
    logic          r_sq_vld [1:SW];
    logic          r_sq_ok  [1:SW];
    logic [XW-1:0] r_sq_x   [1:SW];
    logic [XW-1:0] r_sq_res [1:SW];

    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (SW - 1 - k));
        logic          w_vld_i;
        logic          w_ok_i;
        logic [XW-1:0] w_x_i;
        logic [XW-1:0] w_res_i;
        logic [XW-1:0] w_sum;
        logic          w_take;

        // The first stage takes the quotient straight from the divider.
        if (k == 0) begin : g_first
            assign w_vld_i = r_dv_vld[QW];
            assign w_ok_i  = r_dv_ok[QW];
            assign w_x_i   = XW'(r_dv_q[QW]);
            assign w_res_i = '0;
        end else begin : g_next
            assign w_vld_i = r_sq_vld[k];
            assign w_ok_i  = r_sq_ok[k];
            assign w_x_i   = r_sq_x[k];
            assign w_res_i = r_sq_res[k];
        end

        assign w_sum  = w_res_i + BIT;
        assign w_take = w_x_i >= w_sum;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_vld[k+1] <= w_vld_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_ok[k+1]  <= w_ok_i;
                r_sq_x[k+1]   <= w_take ? w_x_i - w_sum : w_x_i;
                r_sq_res[k+1] <= w_take ? (w_res_i >> 1) + BIT : w_res_i >> 1;
            end
        end
    end

    // Final scaling: offset, magnitude, reciprocal multiply, sign.
    logic                           r_t1_vld, r_t1_ok, r_t1_neg;
    logic [pt1k_pkg::MAG_W-1:0]     r_t1_mag;
    logic                           r_t2_vld, r_t2_ok, r_t2_neg;
    logic [pt1k_pkg::PROD_W-1:0]    r_t2_prod;
    logic                           r_out_vld, r_out_ok;
    logic [pt1k_pkg::T_W-1:0]       r_out_t;
    logic signed [24:0]             w_num;
    logic [pt1k_pkg::T_W-1:0]       w_quot;

    assign w_num  = $signed({1'b0, pt1k_pkg::K_OFFSET})
                  - $signed({2'b00, r_sq_res[SW][SW-1:0]});
    assign w_quot = r_t2_prod[pt1k_pkg::PROD_W-1 -: pt1k_pkg::T_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld  <= 1'b0;
            r_t2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_t1_vld  <= r_sq_vld[SW];
            r_t2_vld  <= r_t1_vld;
            r_out_vld <= r_t2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_ok   <= r_sq_ok[SW];
            r_t1_neg  <= w_num[24];
            r_t1_mag  <= pt1k_pkg::MAG_W'(w_num[24] ? -w_num : w_num);
            r_t2_ok   <= r_t1_ok;
            r_t2_neg  <= r_t1_neg;
            r_t2_prod <= pt1k_pkg::PROD_W'(r_t1_mag) * pt1k_pkg::PROD_W'(pt1k_pkg::K_RECIP);
            r_out_ok  <= r_t2_ok;
            r_out_t   <= !r_t2_ok ? '0 : (r_t2_neg ? -w_quot : w_quot);
        end
    end

    assign o_m_tvalid   = r_out_vld;
    assign o_m_tdata    = {4'b0000, r_out_t};
    assign o_m_tuser[0] = r_out_ok;

    // Checks
    `PT1K_ASSERT_SAME(a_zero_when_out, o_m_tvalid && !o_m_tuser[0], o_m_tdata == 24'd0, "out-of-range result is not zero")
    `PT1K_ASSERT_SAME(a_rem_below_den, r_dv_vld[QW] && r_dv_ok[QW], r_dv_rem[QW] < r_dv_den[QW], "remainder not below divisor")
    `PT1K_ASSERT_SAME(a_temp_floor, o_m_tvalid && o_m_tuser[0], $signed(o_m_tdata[19:0]) >= -20'sd25000, "temperature below floor")
endmodule
`default_nettype wire
